@@ hdl/pzrsb_pkg.sv @@
// Package with the constants, tables and types shared by the polar binning unit.
`timescale 1ns / 1ps
package pzrsb_pkg;

  localparam int COORD_BITS = 16;
  localparam int ANGLE_BITS = 16;
  localparam int CFG_BITS   = 16;
  localparam int RAD_BITS   = COORD_BITS;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int SQRT_STEPS = COORD_BITS;
  localparam int CORDIC_STEPS = 32;
  localparam int CX_BITS    = COORD_BITS + 32;
  localparam int Z_BITS     = 34;
  localparam int T_BITS     = 33;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MIN_RADIUS = 3'd0,
    REG_ZONE_TWO   = 3'd1,
    REG_ZONE_THREE = 3'd2,
    REG_ZONE_FOUR  = 3'd3,
    REG_MAX_RADIUS = 3'd4
  } cfg_reg_t;

  // Arctangent of 2^-i in 2^-32 turns.
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // Ring and sector counts of the four zones.
  function automatic logic [2:0] zone_rings(input logic [1:0] zone);
    logic [2:0] v;
    unique case (zone)
      2'd0: v = 3'd4;
      2'd1: v = 3'd6;
      2'd2: v = 3'd6;
      default: v = 3'd4;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] zone_sectors(input logic [1:0] zone);
    logic [6:0] v;
    unique case (zone)
      2'd0: v = 7'd32;
      2'd1: v = 7'd64;
      2'd2: v = 7'd54;
      default: v = 7'd32;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/polar_zone_ring_sector_binning_unit.sv @@
// Top level of the polar zone, ring and sector binning pipeline.
`timescale 1ns / 1ps
//  Channel   Signals                                          Direction
//  input     in_valid, in_ready, x_pos, y_pos                 item in
//  output    out_valid, out_ready, in_range, zone_index,
//            ring_index, sector_index                         item out
//  config    cfg_we, cfg_addr, cfg_data                       register write
//
//  One item enters per cycle while the output is not stalled; the pipeline has 3 front
//  stages, 32 CORDIC stages that also run the 16 square root steps, and 2 binning stages.
//  Reset clears all valid bits and loads the default boundaries.
//  When the output item is not taken the whole pipeline holds; nothing is lost.
module polar_zone_ring_sector_binning_unit import pzrsb_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] x_pos,
  input  logic signed [COORD_BITS-1:0] y_pos,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         in_range,
  output logic [1:0]                   zone_index,
  output logic [2:0]                   ring_index,
  output logic [5:0]                   sector_index,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_addr,
  input  logic [CFG_BITS-1:0]          cfg_data
);

  logic adv;
  logic [CFG_BITS-1:0] min_radius, zone_two_start, zone_three_start;
  logic [CFG_BITS-1:0] zone_four_start, max_radius;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_radius       <= 16'd819;
      zone_two_start   <= 16'd1971;
      zone_three_start <= 16'd6938;
      zone_four_start  <= 16'd9370;
      max_radius       <= 16'd25600;
    end else if (cfg_we) begin
      priority case (cfg_addr)
        REG_MIN_RADIUS: min_radius       <= cfg_data;
        REG_ZONE_TWO:   zone_two_start   <= cfg_data;
        REG_ZONE_THREE: zone_three_start <= cfg_data;
        REG_ZONE_FOUR:  zone_four_start  <= cfg_data;
        REG_MAX_RADIUS: max_radius       <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances when the output slot is free or being taken.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage one: magnitudes and signs.
  logic                  s1_valid, s1_xneg, s1_yneg;
  logic [COORD_BITS-1:0] s1_ax, s1_ay;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (adv) s1_valid <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_xneg <= x_pos[COORD_BITS-1];
      s1_yneg <= y_pos[COORD_BITS-1];
      s1_ax   <= x_pos[COORD_BITS-1] ? COORD_BITS'(-x_pos) : COORD_BITS'(x_pos);
      s1_ay   <= y_pos[COORD_BITS-1] ? COORD_BITS'(-y_pos) : COORD_BITS'(y_pos);
    end
  end

  // Stage two: squares and exact angle cases.
  logic                  s2_valid, s2_xneg, s2_yneg, s2_ax0, s2_ay0, s2_eq;
  logic [COORD_BITS-1:0] s2_ax, s2_ay;
  logic [SQ_BITS-1:0]    s2_xx, s2_yy;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (adv) s2_valid <= s1_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_xneg <= s1_xneg;
      s2_yneg <= s1_yneg;
      s2_ax   <= s1_ax;
      s2_ay   <= s1_ay;
      s2_ax0  <= (s1_ax == '0);
      s2_ay0  <= (s1_ay == '0);
      s2_eq   <= (s1_ax == s1_ay);
      s2_xx   <= s1_ax * s1_ax;
      s2_yy   <= s1_ay * s1_ay;
    end
  end

  // Iteration registers: index 0 is the start, index k after step k.
  logic                     p_valid [0:CORDIC_STEPS];
  logic                     p_xneg  [0:CORDIC_STEPS];
  logic                     p_yneg  [0:CORDIC_STEPS];
  logic                     p_ax0   [0:CORDIC_STEPS];
  logic                     p_ay0   [0:CORDIC_STEPS];
  logic                     p_eq    [0:CORDIC_STEPS];
  logic signed [CX_BITS-1:0] p_cx   [0:CORDIC_STEPS];
  logic signed [CX_BITS-1:0] p_cy   [0:CORDIC_STEPS];
  logic signed [Z_BITS-1:0]  p_z    [0:CORDIC_STEPS];
  logic [SQ_BITS-1:0]        p_n    [0:CORDIC_STEPS];
  logic [SQ_BITS-1:0]        p_res  [0:CORDIC_STEPS];

  // Stage three: sum of squares and CORDIC start vector.
  always_ff @(posedge clk) begin
    if (rst) p_valid[0] <= 1'b0;
    else if (adv) p_valid[0] <= s2_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p_xneg[0] <= s2_xneg;
      p_yneg[0] <= s2_yneg;
      p_ax0[0]  <= s2_ax0;
      p_ay0[0]  <= s2_ay0;
      p_eq[0]   <= s2_eq;
      p_cx[0]   <= $signed({{(CX_BITS-COORD_BITS-30){1'b0}}, s2_ax, 30'd0});
      p_cy[0]   <= $signed({{(CX_BITS-COORD_BITS-30){1'b0}}, s2_ay, 30'd0});
      p_z[0]    <= '0;
      p_n[0]    <= s2_xx + s2_yy;
      p_res[0]  <= '0;
    end
  end

  // One CORDIC rotation per stage; the first stages also take one root bit each.
  for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_step
    logic signed [CX_BITS-1:0] dx, dy, cx_next, cy_next;
    logic signed [Z_BITS-1:0]  ang, z_next;
    logic [SQ_BITS-1:0]        n_next, res_next;
    logic [SQ_BITS:0]          cand;

    assign dx  = p_cy[k-1] >>> (k-1);
    assign dy  = p_cx[k-1] >>> (k-1);
    assign ang = $signed({{(Z_BITS-32){1'b0}}, ATAN_TURNS[k-1]});

    always_comb begin
      if (p_cy[k-1] >= 0) begin
        cx_next = p_cx[k-1] + dx;
        cy_next = p_cy[k-1] - dy;
        z_next  = p_z[k-1] + ang;
      end else begin
        cx_next = p_cx[k-1] - dx;
        cy_next = p_cy[k-1] + dy;
        z_next  = p_z[k-1] - ang;
      end
    end

    if (k <= SQRT_STEPS) begin : g_root
      localparam logic [SQ_BITS:0] BIT = (SQ_BITS+1)'(1) << (SQ_BITS - 2*k);
      always_comb begin
        cand = {1'b0, p_res[k-1]} + BIT;
        if ({1'b0, p_n[k-1]} >= cand) begin
          n_next   = SQ_BITS'({1'b0, p_n[k-1]} - cand);
          res_next = (p_res[k-1] >> 1) + SQ_BITS'(BIT);
        end else begin
          n_next   = p_n[k-1];
          res_next = p_res[k-1] >> 1;
        end
      end
    end else begin : g_hold
      assign cand     = '0;
      assign n_next   = p_n[k-1];
      assign res_next = p_res[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) p_valid[k] <= 1'b0;
      else if (adv) p_valid[k] <= p_valid[k-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        p_xneg[k] <= p_xneg[k-1];
        p_yneg[k] <= p_yneg[k-1];
        p_ax0[k]  <= p_ax0[k-1];
        p_ay0[k]  <= p_ay0[k-1];
        p_eq[k]   <= p_eq[k-1];
        p_cx[k]   <= cx_next;
        p_cy[k]   <= cy_next;
        p_z[k]    <= z_next;
        p_n[k]    <= n_next;
        p_res[k]  <= res_next;
      end
    end
  end

  // Binning stage A: angle to a turn fraction, zone and its bounds.
  localparam int L = CORDIC_STEPS;
  logic [30:0]           phi;
  logic [T_BITS-1:0]     tt;
  logic [RAD_BITS-1:0]   rad;
  logic [1:0]            zone_c;
  logic [CFG_BITS-1:0]   lower_c, upper_c;

  assign rad = p_res[L][RAD_BITS-1:0];

  always_comb begin
    priority if (p_ay0[L]) phi = '0;
    else if (p_ax0[L]) phi = 31'h4000_0000;
    else if (p_eq[L]) phi = 31'h2000_0000;
    else if (p_z[L] < 0) phi = '0;
    else if (p_z[L] > $signed(Z_BITS'(32'h4000_0000))) phi = 31'h4000_0000;
    else phi = p_z[L][30:0];
  end

  always_comb begin
    unique case ({p_xneg[L], p_yneg[L]})
      2'b00: tt = T_BITS'(phi);
      2'b10: tt = T_BITS'(33'h0_8000_0000) - T_BITS'(phi);
      2'b11: tt = T_BITS'(33'h0_8000_0000) + T_BITS'(phi);
      default: tt = T_BITS'(33'h1_0000_0000) - T_BITS'(phi);
    endcase
  end

  always_comb begin
    priority if (rad < zone_two_start) begin
      zone_c = 2'd0; lower_c = min_radius; upper_c = zone_two_start;
    end else if (rad < zone_three_start) begin
      zone_c = 2'd1; lower_c = zone_two_start; upper_c = zone_three_start;
    end else if (rad < zone_four_start) begin
      zone_c = 2'd2; lower_c = zone_three_start; upper_c = zone_four_start;
    end else begin
      zone_c = 2'd3; lower_c = zone_four_start; upper_c = max_radius;
    end
  end

  logic                  a_valid, a_range, a_ok;
  logic [1:0]            a_zone;
  logic [ANGLE_BITS:0]   a_ang;
  logic [CFG_BITS-1:0]   a_diff, a_width;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (adv) a_valid <= p_valid[L];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a_range <= (rad > min_radius) && (rad <= max_radius);
      a_zone  <= zone_c;
      a_ok    <= (upper_c > lower_c) && (rad >= lower_c);
      a_diff  <= rad - lower_c;
      a_width <= upper_c - lower_c;
      if (tt == '0) a_ang <= (ANGLE_BITS+1)'(1) << ANGLE_BITS;
      else a_ang <= tt[32 -: (ANGLE_BITS+1)] >> 0 & {1'b0, {ANGLE_BITS{1'b1}}}
                    | ((ANGLE_BITS+1)'(tt[32]) << ANGLE_BITS);
    end
  end

  // Binning stage B: ring by threshold counting, sector by multiplying by the zone's sector count.
  logic [CFG_BITS+2:0] prod, thr [1:5];
  logic [2:0]          rings, ring_c;
  logic [6:0]          secs;
  logic [ANGLE_BITS+7:0] sprod;
  logic [ANGLE_BITS+7-ANGLE_BITS:0] sec_raw;
  logic [5:0]          sec_c;

  assign rings = zone_rings(a_zone);
  assign secs  = zone_sectors(a_zone);
  assign prod  = (CFG_BITS+3)'(a_diff) * (CFG_BITS+3)'(rings);

  always_comb begin
    ring_c = '0;
    for (int j = 1; j <= 5; j++) begin
      thr[j] = (CFG_BITS+3)'(a_width) * (CFG_BITS+3)'(j);
      if (a_ok && (3'(j) < rings) && (prod >= thr[j])) ring_c = ring_c + 3'd1;
    end
  end

  assign sprod   = (ANGLE_BITS+8)'(a_ang) * (ANGLE_BITS+8)'(secs);
  assign sec_raw = sprod[ANGLE_BITS+7:ANGLE_BITS];
  assign sec_c   = (sec_raw >= 8'(secs)) ? 6'(secs - 7'd1) : sec_raw[5:0];

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= a_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      in_range     <= a_range;
      zone_index   <= a_range ? a_zone : 2'd0;
      ring_index   <= a_range ? ring_c : 3'd0;
      sector_index <= a_range ? sec_c : 6'd0;
    end
  end

  // Checks on the binning results and the hold behavior.
  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !in_range) |-> (zone_index == 2'd0 && ring_index == 3'd0 &&
                                  sector_index == 6'd0))
    else $error("out-of-range item carries nonzero bins");
  a_ring_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ring_index <= 3'd5))
    else $error("ring index beyond the widest zone");
  a_sec_z2: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zone_index == 2'd2) |-> (sector_index < 6'd54))
    else $error("sector index beyond zone two");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sector_index)))
    else $error("pipeline moved during a stall");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the polar zone, ring and sector binning unit.
`timescale 1ns / 1ps
module tb;
  import pzrsb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 45;
  localparam int HOLD_CYCLES = 300;
  localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REG_SPARE_LAST = 3'd7;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  typedef struct packed {
    logic       in_range;
    logic [1:0] zone;
    logic [2:0] ring;
    logic [5:0] sector;
  } bin_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_BITS-1:0] x_pos = '0;
  logic signed [COORD_BITS-1:0] y_pos = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic in_range;
  logic [1:0] zone_index;
  logic [2:0] ring_index;
  logic [5:0] sector_index;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  // Boundary copies used by the predictor.
  logic [15:0] min_r, zone2_r, zone3_r, zone4_r, max_r;

  point_t pending_points[$];
  bin_t expected_bins[$];
  int fails = 0;
  int cycles = 0;
  int points_taken = 0;
  int send_idle_pct = 36;
  int recv_idle_pct = 79;
  bit point_taken = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  polar_zone_ring_sector_binning_unit u_dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Floored integer square root of a 64-bit value.
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // First-quadrant angle by vectoring rotations, in 2^-32 turns.
  function automatic longint quadrant_angle(longint ax, longint ay);
    longint cx, cy, z, dx, dy;
    if (ay == 0) return 0;
    if (ax == 0) return 64'sd1 << 30;
    if (ax == ay) return 64'sd1 << 29;
    cx = ax << 30;
    cy = ay << 30;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx = cx + dx;
        cy = cy - dy;
        z = z + longint'(ATAN_TURNS[i]);
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        z = z - longint'(ATAN_TURNS[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > (64'sd1 << 30)) z = 64'sd1 << 30;
    return z;
  endfunction

  // Expected bin of one point under the current boundaries.
  function automatic bin_t predict_bin(point_t p);
    bin_t b;
    longint ax, ay, r, phi, t, a, lower, upper, ring, sector, rings, sectors;
    logic [1:0] zone;
    b = '0;
    ax = (p.x < 0) ? -longint'(p.x) : longint'(p.x);
    ay = (p.y < 0) ? -longint'(p.y) : longint'(p.y);
    r = longint'(root_floor(ax * ax + ay * ay));
    if (!(r > min_r && r <= max_r)) return b;
    phi = quadrant_angle(ax, ay);
    if (p.x >= 0 && p.y >= 0) t = phi;
    else if (p.x < 0 && p.y >= 0) t = (64'sd1 << 31) - phi;
    else if (p.x < 0) t = (64'sd1 << 31) + phi;
    else t = (64'sd1 << 32) - phi;
    a = (t == 0) ? (64'sd1 << ANGLE_BITS) : (t >> (32 - ANGLE_BITS));
    if (r < zone2_r) begin
      zone = 2'd0; lower = min_r; upper = zone2_r;
    end else if (r < zone3_r) begin
      zone = 2'd1; lower = zone2_r; upper = zone3_r;
    end else if (r < zone4_r) begin
      zone = 2'd2; lower = zone3_r; upper = zone4_r;
    end else begin
      zone = 2'd3; lower = zone4_r; upper = max_r;
    end
    rings = longint'(zone_rings(zone));
    sectors = longint'(zone_sectors(zone));
    ring = (upper > lower && r >= lower) ? ((r - lower) * rings) / (upper - lower) : 0;
    if (ring > rings - 1) ring = rings - 1;
    sector = (a * sectors) >> ANGLE_BITS;
    if (sector > sectors - 1) sector = sectors - 1;
    b.in_range = 1'b1;
    b.zone = zone;
    b.ring = ring[2:0];
    b.sector = sector[5:0];
    return b;
  endfunction

  // Sender: offers queued points, idling at random between items.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || point_taken) begin
      if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        point_t p;
        p = pending_points.pop_front();
        x_pos <= p.x;
        y_pos <= p.y;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to fill the pipeline.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (!hold_done && points_taken >= 400) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Monitor: records accepted points and checks each result item.
  always @(posedge clk) begin
    point_taken = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        bin_t got, want;
        got = '{in_range, zone_index, ring_index, sector_index};
        if (expected_bins.size() == 0) begin
          $display("%0t: result with nothing expected: %p", $time, got);
          fails++;
        end else begin
          want = expected_bins.pop_front();
          if (got.in_range !== want.in_range) begin
            $display("%0t: in_range expected %0d actual %0d", $time, want.in_range, got.in_range);
            fails++;
          end
          if (got.zone !== want.zone) begin
            $display("%0t: zone_index expected %0d actual %0d", $time, want.zone, got.zone);
            fails++;
          end
          if (got.ring !== want.ring) begin
            $display("%0t: ring_index expected %0d actual %0d", $time, want.ring, got.ring);
            fails++;
          end
          if (got.sector !== want.sector) begin
            $display("%0t: sector_index expected %0d actual %0d", $time, want.sector,
                     got.sector);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_bins.insert(expected_bins.size(), predict_bin('{x_pos, y_pos}));
        point_taken = 1'b1;
        points_taken++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    case (idx)
      REG_MIN_RADIUS: min_r = value;
      REG_ZONE_TWO: zone2_r = value;
      REG_ZONE_THREE: zone3_r = value;
      REG_ZONE_FOUR: zone4_r = value;
      REG_MAX_RADIUS: max_r = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_bounds(int lo, int z2, int z3, int z4, int hi);
    write_reg(REG_MIN_RADIUS, 16'(lo));
    write_reg(REG_ZONE_TWO, 16'(z2));
    write_reg(REG_ZONE_THREE, 16'(z3));
    write_reg(REG_ZONE_FOUR, 16'(z4));
    write_reg(REG_MAX_RADIUS, 16'(hi));
  endtask

  // Checks just after the falling edge, once the sender has settled.
  task automatic wait_drained();
    do begin
      @(negedge clk);
      #1;
    end while (pending_points.size() > 0 || in_valid || expected_bins.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic add_point(int x, int y);
    pending_points.insert(pending_points.size(), '{x[15:0], y[15:0]});
  endtask

  // Random points: mostly at radii near the boundaries, some of any size.
  task automatic add_random_points(int count);
    int mag, ang_x, ang_y, bits;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1: begin
          add_point($urandom, $urandom);
        end
        2: begin
          bits = $urandom_range(15, 1);
          add_point($signed($urandom) >>> (32 - bits), $signed($urandom) >>> (32 - bits));
        end
        3: begin
          mag = $urandom_range(32767);
          case ($urandom_range(3))
            0: add_point(mag, 0);
            1: add_point(-mag, 0);
            2: add_point(0, $urandom_range(1) ? mag : -mag);
            default: add_point($urandom_range(1) ? mag : -mag, $urandom_range(1) ? mag : -mag);
          endcase
        end
        default: begin
          case ($urandom_range(4))
            0: mag = min_r;
            1: mag = zone2_r;
            2: mag = zone3_r;
            3: mag = zone4_r;
            default: mag = max_r;
          endcase
          mag = mag + $urandom_range(8) - 4;
          if (mag > 32767) mag = 32767;
          if (mag < 0) mag = 0;
          ang_x = $urandom_range(mag);
          ang_y = mag - ang_x / 2;
          if (ang_y > 32767) ang_y = 32767;
          add_point($urandom_range(1) ? ang_x : -ang_x, $urandom_range(1) ? ang_y : -ang_y);
        end
      endcase
    end
  endtask

  task automatic run_phase(int count, int regime);
    case (regime % 3)
      0: begin send_idle_pct = 36; recv_idle_pct = 79; end
      1: begin send_idle_pct = 79; recv_idle_pct = 36; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
    add_random_points(count);
    wait_drained();
  endtask

  initial begin
    min_r = 16'd819;
    zone2_r = 16'd1971;
    zone3_r = 16'd6938;
    zone4_r = 16'd9370;
    max_r = 16'd25600;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed points under the default boundaries.
    add_point(0, 0);
    add_point(-32768, -32768);
    add_point(32767, 32767);
    add_point(-32768, 32767);
    add_point(32767, -32768);
    add_point(1000, 0);
    add_point(-1000, 0);
    add_point(0, 1000);
    add_point(0, -1000);
    add_point(1000, 1000);
    add_point(-1000, 1000);
    add_point(-1000, -1000);
    add_point(1000, -1000);
    add_point(1000, -1);
    add_point(819, 0);
    add_point(820, 0);
    add_point(1970, 0);
    add_point(1971, 0);
    add_point(6938, 0);
    add_point(9370, 0);
    add_point(25600, 0);
    add_point(25601, 0);
    add_point(-3, 9000);
    wait_drained();

    // Writes to unused register indexes must change nothing.
    for (int idx = REG_SPARE_FIRST; idx <= REG_SPARE_LAST; idx++)
      write_reg(idx[2:0], 16'h0000);
    run_phase(250, 0);

    // Widest span, zero-width outer zone at the top.
    set_bounds(0, 100, 5000, 46341, 46341);
    add_point(-32768, -32768);
    add_point(32767, 32767);
    run_phase(250, 1);

    // Everything collapses to zero: nothing is in range.
    set_bounds(0, 0, 0, 0, 0);
    run_phase(150, 2);

    // Misordered boundaries.
    set_bounds(20000, 300, 40000, 1000, 30000);
    run_phase(250, 0);

    // Zero-width outer zone in the middle of the span.
    set_bounds(10, 2000, 4000, 8000, 8000);
    add_point(8000, 0);
    add_point(-8000, 0);
    run_phase(250, 1);

    // Full 16-bit values and narrow zones.
    set_bounds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(100, 2);
    set_bounds(1, 2, 3, 4, 46341);
    run_phase(250, 0);

    // Back to defaults, with no idling at all.
    set_bounds(819, 1971, 6938, 9370, 25600);
    run_phase(350, 2);

    if (fails == 0 && expected_bins.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
